// ===== hw/rtl/pfra_pkg.sv =====
`default_nettype none

package pfra_pkg;

  // Fixed field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned FRAME_W = 15;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned ST_W    = 3;
  localparam int unsigned CFG_W   = 16;
  // Bounds are carried one bit wider than the config registers so that the
  // clamp against the frame count (up to 65536) fits.
  localparam int unsigned BND_W   = 17;

  localparam logic [CFG_W-1:0] HIGH_FRAME_RST = 16'd32768;
  localparam logic [CNT_W-1:0] CNT_MAX        = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_SHARE = 2'd2,
    OP_QUERY = 2'd3
  } pfra_op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOFREE   = 3'd1,
    ST_RANGE    = 3'd2,
    ST_FREED    = 3'd3,
    ST_RESERVED = 3'd4,
    ST_SAT      = 3'd5
  } pfra_status_e;

  typedef enum logic {
    CFG_LOW_FRAME  = 1'b0,
    CFG_HIGH_FRAME = 1'b1
  } pfra_cfg_idx_e;

  // What the back end has to do with a queued command
  typedef enum logic [2:0] {
    K_EARLY = 3'd0,   // result already known, no count access
    K_ALLOC = 3'd1,
    K_FREE  = 3'd2,
    K_SHARE = 3'd3,
    K_QUERY = 3'd4
  } pfra_kind_e;

  typedef struct packed {
    pfra_kind_e         kind;
    pfra_status_e       status;  // only meaningful for K_EARLY
    logic [FRAME_W-1:0] frame;
  } pfra_cmd_t;

  typedef struct packed {
    logic [BND_W-1:0] lo;
    logic [BND_W-1:0] hi;
  } pfra_bounds_t;

  typedef struct packed {
    logic clearing;
  } pfra_back_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/page_frame_refcount_allocator_top.sv =====
`default_nettype none

// Channel     | Dir | Handshake                      | Payload
// s_axis      | in  | s_axis_tvalid_i/s_axis_tready_o | opcode, frame_number
// m_axis      | out | m_axis_tvalid_o/m_axis_tready_i | status, result_frame, ref_count
// cfg         | in  | cfg_wr_en_i (no stall)          | cfg_idx_i, cfg_data_i
//
// Order: one item at a time in the back end. Free, share and query that
// reach the counts go through pop + count read, modify/write, result;
// items answered by the front (reserved, out of range, empty alloc window)
// go through pop, result. Alloc pops, then scans down from high_frame-1,
// one count read per cycle from the single-ported count memory, until it
// finds a zero count or reaches the low bound.
// Reset: the count memory is swept to zero, one entry per cycle, after
// reset; s_axis_tready_o stays low meanwhile, cfg writes work.
// Stalls: a 2-entry command queue decouples input from the back end; the
// back end holds off while a result waits in the output register.

module page_frame_refcount_allocator_top #(
  parameter int unsigned FRAMES = 32768
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // [1:0] opcode, [16:2] frame_number, [23:17] zero
  input  wire logic [23:0] s_axis_tdata_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [2:0] status, [17:3] result_frame, [25:18] ref_count, [31:26] zero
  output logic [31:0]      m_axis_tdata_o,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  input  wire logic        cfg_wr_en_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  import pfra_pkg::*;

  pfra_cmd_t         push_cmd, head_cmd;
  pfra_bounds_t      bounds;
  pfra_back_status_t back_status;
  logic              q_push, q_pop, q_full, q_empty;
  logic [ST_W-1:0]    out_status;
  logic [FRAME_W-1:0] out_frame;
  logic [CNT_W-1:0]   out_count;

  // front: config registers, bound clamp, command classification
  pfra_front #(
    .FRAMES(FRAMES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_op_i      (s_axis_tdata_i[1:0]),
    .in_frame_i   (s_axis_tdata_i[16:2]),
    .back_status_i(back_status),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (push_cmd),
    .bounds_o     (bounds)
  );

  pfra_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (push_cmd),
    .pop_i  (q_pop),
    .cmd_o  (head_cmd),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  // back: count memory, clear sweep, read-modify-write and alloc scan
  pfra_back #(
    .FRAMES(FRAMES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bounds_i    (bounds),
    .q_empty_i   (q_empty),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (q_pop),
    .status_o    (back_status),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_status_o(out_status),
    .out_frame_o (out_frame),
    .out_count_o (out_count)
  );

  assign m_axis_tdata_o = {6'b0, out_count, out_frame, out_status};

  // no input transfer during the clear sweep
  a_no_accept_while_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.clearing |-> !s_axis_tready_o)
    else $error("input accepted during count clear");

  // queue never pushed when full or popped when empty
  a_queue_bounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full) && !(q_pop && q_empty))
    else $error("command queue overflow or underflow");

  // a failed alloc reports frame 0 and count 0
  a_nofree_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_status == ST_NOFREE) |-> (out_frame == '0 && out_count == '0))
    else $error("no-free result carries nonzero payload");

endmodule

`default_nettype wire

// ===== hw/rtl/pfra_front.sv =====
`default_nettype none

module pfra_front #(
  parameter int unsigned FRAMES = 32768
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_wr_en_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [pfra_pkg::CFG_W-1:0]    cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [pfra_pkg::OP_W-1:0]     in_op_i,
  input  wire logic [pfra_pkg::FRAME_W-1:0]  in_frame_i,
  input  wire pfra_pkg::pfra_back_status_t   back_status_i,
  input  wire logic                          q_full_i,
  output logic                               q_push_o,
  output pfra_pkg::pfra_cmd_t                q_cmd_o,
  output pfra_pkg::pfra_bounds_t             bounds_o
);
  import pfra_pkg::*;

  localparam logic [BND_W-1:0] FramesB = BND_W'(FRAMES);

  logic [CFG_W-1:0] low_q, high_q;
  logic [BND_W-1:0] lo_ext, hi_ext, lo_c, hi_c, fr_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= HIGH_FRAME_RST;
    end else if (cfg_wr_en_i) begin
      case (pfra_cfg_idx_e'(cfg_idx_i))
        CFG_LOW_FRAME:  low_q  <= cfg_data_i;
        CFG_HIGH_FRAME: high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign lo_ext = {1'b0, low_q};
  assign hi_ext = {1'b0, high_q};
  assign lo_c   = (lo_ext > FramesB) ? FramesB : lo_ext;
  assign hi_c   = (hi_ext > FramesB) ? FramesB : hi_ext;
  assign fr_ext = BND_W'(in_frame_i);

  assign bounds_o.lo = lo_c;
  assign bounds_o.hi = hi_c;

  assign in_ready_o = !q_full_i && !back_status_i.clearing;
  assign q_push_o   = in_valid_i && in_ready_o;

  always_comb begin
    q_cmd_o.kind   = K_EARLY;
    q_cmd_o.status = ST_OK;
    q_cmd_o.frame  = in_frame_i;
    case (pfra_op_e'(in_op_i))
      OP_ALLOC: begin
        q_cmd_o.frame = '0;
        if (lo_c >= hi_c) begin
          q_cmd_o.status = ST_NOFREE;
        end else begin
          q_cmd_o.kind = K_ALLOC;
        end
      end
      OP_FREE: begin
        // reserved check wins over the upper bound
        if (fr_ext < lo_c) begin
          q_cmd_o.status = ST_RESERVED;
        end else if (fr_ext >= hi_c) begin
          q_cmd_o.status = ST_RANGE;
        end else begin
          q_cmd_o.kind = K_FREE;
        end
      end
      OP_SHARE, OP_QUERY: begin
        if (fr_ext < lo_c || fr_ext >= hi_c) begin
          q_cmd_o.status = ST_RANGE;
        end else begin
          q_cmd_o.kind = (pfra_op_e'(in_op_i) == OP_SHARE) ? K_SHARE : K_QUERY;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pfra_cmd_fifo.sv =====
`default_nettype none

module pfra_cmd_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire pfra_pkg::pfra_cmd_t  cmd_i,
  input  wire logic                 pop_i,
  output pfra_pkg::pfra_cmd_t       cmd_o,
  output logic                      full_o,
  output logic                      empty_o
);
  import pfra_pkg::*;

  // two entries: one pointer bit
  pfra_cmd_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pfra_back.sv =====
`default_nettype none

module pfra_back #(
  parameter int unsigned FRAMES = 32768
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pfra_pkg::pfra_bounds_t        bounds_i,
  input  wire logic                          q_empty_i,
  input  wire pfra_pkg::pfra_cmd_t           q_cmd_i,
  output logic                               q_pop_o,
  output pfra_pkg::pfra_back_status_t        status_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [pfra_pkg::ST_W-1:0]          out_status_o,
  output logic [pfra_pkg::FRAME_W-1:0]       out_frame_o,
  output logic [pfra_pkg::CNT_W-1:0]         out_count_o
);
  import pfra_pkg::*;

  localparam int unsigned AW = $clog2(FRAMES);
  localparam logic [AW-1:0] LastAddr = AW'(FRAMES - 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_RMW   = 4'b0100,
    S_SCAN  = 4'b1000
  } pfra_state_e;

  pfra_state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] chk_q, chk_d;
  pfra_cmd_t     cmd_q, cmd_d;

  logic               out_valid_q, out_valid_d;
  pfra_status_e       out_st_q, out_st_d;
  logic [FRAME_W-1:0] out_fr_q, out_fr_d;
  logic [CNT_W-1:0]   out_cnt_q, out_cnt_d;

  logic [CNT_W-1:0] mem [FRAMES];
  logic [CNT_W-1:0] rd_data_q;
  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [CNT_W-1:0] wr_data;

  logic [AW-1:0]    in_idx, cur_idx, lo_idx, alloc_start;
  logic [BND_W-1:0] hi_m1;

  assign in_idx      = AW'(BND_W'(q_cmd_i.frame));
  assign cur_idx     = AW'(BND_W'(cmd_q.frame));
  assign lo_idx      = bounds_i.lo[AW-1:0];
  assign hi_m1       = bounds_i.hi - BND_W'(1);
  assign alloc_start = hi_m1[AW-1:0];

  assign status_o.clearing = (state_q == S_CLEAR);
  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_st_q;
  assign out_frame_o       = out_fr_q;
  assign out_count_o       = out_cnt_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    chk_d       = chk_q;
    cmd_d       = cmd_q;
    out_valid_d = out_valid_q;
    out_st_d    = out_st_q;
    out_fr_d    = out_fr_q;
    out_cnt_d   = out_cnt_q;
    q_pop_o     = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        if (clr_q == LastAddr) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (!q_empty_i && !out_valid_q) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          case (q_cmd_i.kind)
            K_EARLY: begin
              out_valid_d = 1'b1;
              out_st_d    = q_cmd_i.status;
              out_fr_d    = q_cmd_i.frame;
              out_cnt_d   = '0;
            end
            K_ALLOC: begin
              rd_en   = 1'b1;
              rd_addr = alloc_start;
              chk_d   = alloc_start;
              state_d = S_SCAN;
            end
            default: begin
              rd_en   = 1'b1;
              rd_addr = in_idx;
              state_d = S_RMW;
            end
          endcase
        end
      end
      S_RMW: begin
        out_valid_d = 1'b1;
        out_fr_d    = cmd_q.frame;
        out_st_d    = ST_OK;
        out_cnt_d   = rd_data_q;
        state_d     = S_IDLE;
        case (cmd_q.kind)
          K_FREE: begin
            if (rd_data_q == '0) begin
              out_st_d = ST_FREED;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = cur_idx;
              wr_data   = rd_data_q - CNT_W'(1);
              out_cnt_d = wr_data;
            end
          end
          K_SHARE: begin
            if (rd_data_q == CNT_MAX) begin
              out_st_d = ST_SAT;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = cur_idx;
              wr_data   = rd_data_q + CNT_W'(1);
              out_cnt_d = wr_data;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        // rd_data_q holds the count of chk_q
        if (rd_data_q == '0) begin
          wr_en       = 1'b1;
          wr_addr     = chk_q;
          wr_data     = CNT_W'(1);
          out_valid_d = 1'b1;
          out_st_d    = ST_OK;
          out_fr_d    = FRAME_W'(chk_q);
          out_cnt_d   = CNT_W'(1);
          state_d     = S_IDLE;
        end else if (chk_q == lo_idx) begin
          out_valid_d = 1'b1;
          out_st_d    = ST_NOFREE;
          out_fr_d    = '0;
          out_cnt_d   = '0;
          state_d     = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = chk_q - AW'(1);
          chk_d   = chk_q - AW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_q     <= chk_d;
    cmd_q     <= cmd_d;
    out_st_q  <= out_st_d;
    out_fr_q  <= out_fr_d;
    out_cnt_q <= out_cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== test/refcount_checker.sv =====
`timescale 1ns / 100ps

module refcount_checker #(
  parameter int unsigned FRAMES = 32768
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [23:0] s_axis_tdata_i,
  input  wire logic        s_axis_tvalid_i,
  input  wire logic        s_axis_tready_i,
  input  wire logic [31:0] m_axis_tdata_i,
  input  wire logic        m_axis_tvalid_i,
  input  wire logic        m_axis_tready_i,
  input  wire logic        cfg_wr_en_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  output int               errors_o,
  output int               pending_o,
  output int               results_o,
  output logic [5:0]       status_seen_o
);
  import pfra_pkg::*;

  typedef struct packed {
    pfra_status_e       status;
    logic [FRAME_W-1:0] frame;
    logic [CNT_W-1:0]   count;
  } refcount_result_t;

  // Shadow of the count store and the bound registers
  logic [CNT_W-1:0] frame_cnt [FRAMES];
  logic [CFG_W-1:0] low_reg;
  logic [CFG_W-1:0] high_reg;

  refcount_result_t expected_q[$];
  refcount_result_t want;
  refcount_result_t got;
  refcount_result_t fresh;
  int               fail_cnt;
  int               result_cnt;
  logic [5:0]       seen;
  logic             bad;

  assign errors_o      = fail_cnt;
  assign results_o     = result_cnt;
  assign status_seen_o = seen;

  function automatic int clamp_bound(logic [CFG_W-1:0] v);
    return (int'(v) > int'(FRAMES)) ? int'(FRAMES) : int'(v);
  endfunction

  task automatic predict_command(input pfra_op_e op, input logic [FRAME_W-1:0] fr,
                                 output refcount_result_t res);
    int lo;
    int hi;
    int f;
    int i;
    lo = clamp_bound(low_reg);
    hi = clamp_bound(high_reg);
    f  = int'(fr);
    res.status = ST_OK;
    res.frame  = fr;
    res.count  = '0;
    case (op)
      OP_ALLOC: begin
        // top-down scan for the first zero count
        res.status = ST_NOFREE;
        res.frame  = '0;
        for (i = hi - 1; i >= lo && res.status == ST_NOFREE; i--) begin
          if (frame_cnt[i] == '0) begin
            frame_cnt[i] = 8'd1;
            res.status   = ST_OK;
            res.frame    = i[FRAME_W-1:0];
            res.count    = 8'd1;
          end
        end
      end
      OP_FREE: begin
        if (f < lo) begin
          res.status = ST_RESERVED;
        end else if (f >= hi) begin
          res.status = ST_RANGE;
        end else if (frame_cnt[f] == '0) begin
          res.status = ST_FREED;
        end else begin
          frame_cnt[f] = frame_cnt[f] - 8'd1;
          res.count    = frame_cnt[f];
        end
      end
      default: begin
        if (f < lo || f >= hi) begin
          res.status = ST_RANGE;
        end else if (op == OP_SHARE) begin
          if (frame_cnt[f] == CNT_MAX) begin
            res.status = ST_SAT;
            res.count  = CNT_MAX;
          end else begin
            frame_cnt[f] = frame_cnt[f] + 8'd1;
            res.count    = frame_cnt[f];
          end
        end else begin
          res.count = frame_cnt[f];
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < int'(FRAMES); j++) frame_cnt[j] = '0;
      low_reg  = '0;
      high_reg = HIGH_FRAME_RST;
      expected_q.delete();
      fail_cnt   = 0;
      result_cnt = 0;
      seen       = '0;
      pending_o <= 0;
    end else begin
      if (cfg_wr_en_i) begin
        if (pfra_cfg_idx_e'(cfg_idx_i) == CFG_LOW_FRAME) low_reg = cfg_data_i;
        else high_reg = cfg_data_i;
      end

      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.status = pfra_status_e'(m_axis_tdata_i[2:0]);
        got.frame  = m_axis_tdata_i[17:3];
        got.count  = m_axis_tdata_i[25:18];
        result_cnt++;
        if (m_axis_tdata_i[2:0] <= ST_SAT) seen[m_axis_tdata_i[2:0]] = 1'b1;
        if (expected_q.size() == 0) begin
          $display("%0t unexpected result: status %0d frame %0d count %0d",
                   $time, got.status, got.frame, got.count);
          fail_cnt++;
        end else begin
          want = expected_q.pop_front();
          bad  = 1'b0;
          if (got.status !== want.status) begin
            $display("%0t status mismatch: expected %0d actual %0d",
                     $time, want.status, got.status);
            bad = 1'b1;
          end
          if (got.frame !== want.frame) begin
            $display("%0t result_frame mismatch: expected %0d actual %0d",
                     $time, want.frame, got.frame);
            bad = 1'b1;
          end
          if (got.count !== want.count) begin
            $display("%0t ref_count mismatch: expected %0d actual %0d",
                     $time, want.count, got.count);
            bad = 1'b1;
          end
          if (bad) fail_cnt++;
        end
      end

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_command(pfra_op_e'(s_axis_tdata_i[1:0]), s_axis_tdata_i[16:2], fresh);
        expected_q.push_back(fresh);
      end

      pending_o <= expected_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import pfra_pkg::*;

  localparam int unsigned FRAMES = 32768;
  // Longest quiet stretch: the post-reset sweep of all FRAMES entries or a full
  // downward scan, plus stalls; taken several times over.
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int TAIL_CYCLES    = 20;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic [23:0] s_data    = '0;
  logic        s_valid   = 1'b0;
  wire         s_ready;
  wire  [31:0] m_data;
  wire         m_valid;
  logic        m_ready   = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_idx   = 1'b0;
  logic [15:0] cfg_data  = '0;

  int         errors;
  int         pending;
  int         results;
  logic [5:0] status_seen;

  // steady: no idling on either side for the current burst
  logic steady      = 1'b0;
  int   cmds_sent   = 0;
  int   bound_sets  = 0;
  int   idle_cycles = 0;

  always #2 clk = ~clk;

  page_frame_refcount_allocator_top #(
    .FRAMES(FRAMES)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tdata_i (s_data),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .cfg_wr_en_i    (cfg_wr_en),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  // Watches both streams and the cfg port, predicts and compares
  refcount_checker #(
    .FRAMES(FRAMES)
  ) refcount_chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tdata_i (s_data),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_i(s_ready),
    .m_axis_tdata_i (m_data),
    .m_axis_tvalid_i(m_valid),
    .m_axis_tready_i(m_ready),
    .cfg_wr_en_i    (cfg_wr_en),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .errors_o       (errors),
    .pending_o      (pending),
    .results_o      (results),
    .status_seen_o  (status_seen)
  );

  // One command transfer: random gap with tvalid low, then hold until taken.
  // tvalid stays high on return so a zero gap gives back-to-back transfers.
  task automatic send_command(input pfra_op_e op, input logic [FRAME_W-1:0] fr);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_data  <= {7'd0, fr, op};
    s_valid <= 1'b1;
    do @(posedge clk); while (!s_ready);
    cmds_sent++;
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic drain_results();
    s_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Both bound registers, back to back; only called with the block idle
  task automatic set_bounds(input logic [15:0] lo, input logic [15:0] hi);
    cfg_wr_en <= 1'b1;
    cfg_idx   <= CFG_LOW_FRAME;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_idx   <= CFG_HIGH_FRAME;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    bound_sets++;
  endtask

  // A random burst under one bound setting. Frames mostly land in the
  // managed window, some on its edges, the rest anywhere. The hot mode
  // hammers a tiny window with shares to push counts into saturation.
  task automatic run_burst(input int lo_v, input int hi_v, input int n, input bit hot);
    int lo_c;
    int hi_c;
    int roll;
    int pick;
    pfra_op_e op;
    logic [FRAME_W-1:0] fr;
    drain_results();
    set_bounds(lo_v[15:0], hi_v[15:0]);
    lo_c = (int'(lo_v[15:0]) > int'(FRAMES)) ? int'(FRAMES) : int'(lo_v[15:0]);
    hi_c = (int'(hi_v[15:0]) > int'(FRAMES)) ? int'(FRAMES) : int'(hi_v[15:0]);
    steady <= ($urandom_range(0, 3) == 0);
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (hot) begin
        if (roll < 85)      op = OP_SHARE;
        else if (roll < 90) op = OP_FREE;
        else if (roll < 95) op = OP_QUERY;
        else                op = OP_ALLOC;
      end else begin
        if (roll < 30)      op = OP_ALLOC;
        else if (roll < 60) op = OP_FREE;
        else if (roll < 80) op = OP_SHARE;
        else                op = OP_QUERY;
      end
      pick = $urandom_range(0, 99);
      if (hi_c > lo_c && (pick < 65 || (hot && pick < 95))) begin
        fr = 15'(lo_c + int'($urandom_range(0, hi_c - lo_c - 1)));
      end else if (pick < 85) begin
        case ($urandom_range(0, 3))
          0:       fr = 15'(lo_c - 1);
          1:       fr = 15'(lo_c);
          2:       fr = 15'(hi_c - 1);
          default: fr = 15'(hi_c);
        endcase
      end else begin
        fr = 15'($urandom_range(0, 32767));
      end
      send_command(op, fr);
    end
  endtask

  // Result side: random stall per transfer, taken back when steady
  initial begin : result_sink
    int stall;
    @(posedge rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_ready <= 1'b1;
      do @(posedge clk); while (!m_valid);
    end
  end

  // Watchdog: any transfer or cfg write counts as progress
  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[page_frame_refcount_allocator_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int base;
    int width;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed, reset bounds (whole frame space) ---
    send_command(OP_ALLOC, 15'd0);        // top frame
    send_command(OP_ALLOC, 15'h7FFF);     // frame field ignored, next one down
    send_command(OP_SHARE, 15'h7FFF);
    send_command(OP_QUERY, 15'h7FFF);
    send_command(OP_FREE,  15'h7FFF);
    send_command(OP_FREE,  15'h7FFF);     // back to zero
    send_command(OP_FREE,  15'h7FFF);     // already free
    send_command(OP_SHARE, 15'd0);        // share of a free frame
    send_command(OP_QUERY, 15'd0);
    send_command(OP_FREE,  15'd0);
    send_command(OP_QUERY, 15'd0);

    // narrow window: reserved, out of range, exhaustion, reuse
    drain_results();
    set_bounds(16'd16, 16'd20);
    send_command(OP_FREE,  15'd5);        // below window: ignored
    send_command(OP_FREE,  15'd20);       // at high bound
    send_command(OP_SHARE, 15'd5);
    send_command(OP_QUERY, 15'd20);
    repeat (4) send_command(OP_ALLOC, 15'd0);
    send_command(OP_ALLOC, 15'd0);        // nothing left
    send_command(OP_FREE,  15'd16);
    send_command(OP_ALLOC, 15'd0);        // picks the freed frame

    // inverted window: empty range
    drain_results();
    set_bounds(16'd300, 16'd200);
    send_command(OP_ALLOC, 15'd0);
    send_command(OP_FREE,  15'd250);      // below low wins over above high

    // both bounds past the frame count, clamped
    drain_results();
    set_bounds(16'hFFFF, 16'hFFFF);
    send_command(OP_FREE,  15'h7FFF);
    send_command(OP_QUERY, 15'h7FFF);

    // --- random bursts ---
    run_burst(0, 32768, 200, 1'b0);
    base  = $urandom_range(0, 32700);
    width = $urandom_range(4, 48);
    run_burst(base, base + width, 200, 1'b0);
    base = $urandom_range(0, 32760);
    run_burst(base, base + 3, 120, 1'b0);         // tiny, mostly exhausted
    base = $urandom_range(0, 32767);
    run_burst(base, base + 1, 330, 1'b1);         // one frame, saturation
    run_burst(0, 16'hFFFF, 150, 1'b0);            // high bound clamped
    run_burst($urandom_range(32700, 32767), $urandom_range(32768, 65535), 150, 1'b0);
    run_burst(16'hFFFF, 0, 60, 1'b0);             // extreme empty range
    base = $urandom_range(1, 32767);
    run_burst(base, $urandom_range(0, base - 1), 40, 1'b0);

    // pipeline must be empty; then give stray results a chance to show up
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d commands over %0d bound settings, %0d results checked.",
             cmds_sent, bound_sets, results);
    $display("Statuses seen (sat, reserved, freed, range, nofree, ok): %b", status_seen);
    if (errors == 0 && pending == 0) begin
      $display("[page_frame_refcount_allocator_top] OK");
    end else begin
      $display("[page_frame_refcount_allocator_top] ERROR");
    end
    $finish;
  end

endmodule
